>>> rtl/dedup_top_k_selector_top_defines.svh
// Assertion macros for the top-k selector
`ifndef DEDUP_TOP_K_SELECTOR_TOP_DEFINES_SVH
`define DEDUP_TOP_K_SELECTOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define DTK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DTK_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DTK_ASSERT(label, clk, rst, prop, msg)
`define DTK_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

>>> rtl/dtks_pkg.sv
package dtks_pkg;
  localparam int MaxEntries = 64;
  localparam int IdxW = $clog2(MaxEntries);
  localparam int CntW = $clog2(MaxEntries + 1);

  localparam logic [2:0] ST_REJECT  = 3'd0;
  localparam logic [2:0] ST_INSERT  = 3'd1;
  localparam logic [2:0] ST_REP_DUP = 3'd2;
  localparam logic [2:0] ST_REP_WST = 3'd3;
  localparam logic [2:0] ST_DRAINED = 3'd4;
  localparam logic [2:0] ST_EMPTY   = 3'd5;

  localparam logic REQ_PUSH  = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic signed [63:0] score;
    logic [31:0] tag;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        entry_present;
    logic [63:0] out_key_high;
    logic [63:0] out_key_low;
    logic signed [63:0] out_score;
    logic [31:0] out_tag;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic signed [63:0] score;
    logic [31:0] tag;
  } cand_t;

  // strict order: lower score, then lower key_high, then key_low
  function automatic logic better(cand_t a, cand_t b);
    if (a.score != b.score) return a.score < b.score;
    if (a.key_high != b.key_high) return a.key_high < b.key_high;
    return a.key_low < b.key_low;
  endfunction
endpackage

>>> rtl/dtks_ram.sv
module dtks_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/dedup_top_k_selector_top.sv
// Deduplicating top-k selector. Holds up to the configured width (at most 64)
// candidates with distinct 128-bit keys in a single-port-read entry RAM; lower
// score is better, ties go to the lower key. A push, and a drain of a
// non-empty store, scan the held entries, one entry per cycle; a push with
// width zero or a drain of an empty store answers without a scan. A push
// first scans for its key and, when the store is full, scans again to find
// the worst entry. A drain runs one selection scan per emitted word, then
// emits the word (waiting for the output), moves the top entry into the
// emitted slot and lets the RAM settle. Read data is used only from slots
// below the live count. The block takes no new word until the
// last result is taken.
`include "dedup_top_k_selector_top_defines.svh"
module dedup_top_k_selector_top
  import dtks_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  req_t        in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output rsp_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DUP   = 3'd1;
  localparam logic [2:0] S_WORST = 3'd2;
  localparam logic [2:0] S_SEL   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;
  localparam logic [2:0] S_MOVE  = 3'd6;
  localparam logic [2:0] S_WAIT  = 3'd7;

  localparam logic [2:0] REG_BEAM = 3'd0;

  logic [2:0]      state;
  logic [6:0]      keep_width;
  logic [CntW-1:0] live_count;
  logic [CntW-1:0] scan;       // address issued
  logic [CntW-1:0] rd_idx;     // address of data now on ram output
  logic            rd_vld;
  req_t            req;
  cand_t           best;       // current pick in a scan
  logic [IdxW-1:0] best_idx;
  logic            have_best;
  logic [CntW-1:0] remain;     // drain: entries still held (compacted)
  logic [CntW-1:0] mv_src;

  // entry RAM
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  cand_t           ram_wdata, ram_rdata;

  dtks_ram #(.Width($bits(cand_t)), .Depth(MaxEntries)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  cand_t in_cand;
  assign in_cand = '{key_high: req.key_high, key_low: req.key_low,
                     score: req.score, tag: req.tag};

  logic [CntW-1:0] width_eff;
  assign width_eff = (keep_width > 7'(MaxEntries)) ? CntW'(MaxEntries)
                                                    : CntW'(keep_width);

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr == REG_BEAM) ? {25'd0, keep_width} : 32'd0;

  assign in_ready = (state == S_IDLE) && !out_valid;

  // the move source is read while in S_OUT so its data is there in S_MOVE
  always_comb begin
    ram_raddr = scan[IdxW-1:0];
    if (state == S_OUT || state == S_MOVE) ram_raddr = mv_src[IdxW-1:0];
  end

  logic dup_hit;
  assign dup_hit = rd_vld && ram_rdata.key_high == req.key_high &&
                   ram_rdata.key_low == req.key_low;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      keep_width <= 7'd1;
      live_count <= '0;
      out_valid  <= 1'b0;
      ram_we     <= 1'b0;
      rd_vld     <= 1'b0;
    end else begin
      // write strobe is a one-cycle pulse
      if (ram_we) ram_we <= 1'b0;
      if (psel && penable && pwrite && paddr == REG_BEAM)
        keep_width <= pwdata[6:0];
      if (out_valid && out_ready) out_valid <= 1'b0;
      // registered ram read: track which address the output data belongs to
      rd_idx <= scan;
      unique case (state)
        S_IDLE: begin
          rd_vld <= 1'b0;
          if (in_valid && in_ready) begin
            req  <= in_data;
            scan <= '0;
            have_best <= 1'b0;
            if (in_data.req_type == REQ_DRAIN) begin
              if (live_count == '0) begin
                out_valid <= 1'b1;
                out_data  <= '{status: ST_EMPTY, entry_present: 1'b0,
                               out_key_high: '0, out_key_low: '0,
                               out_score: '0, out_tag: '0, last: 1'b1};
              end else begin
                remain <= live_count;
                state  <= S_SEL;
              end
            end else if (keep_width == 7'd0) begin
              out_valid <= 1'b1;
              out_data  <= '{status: ST_REJECT, entry_present: 1'b0,
                             out_key_high: '0, out_key_low: '0,
                             out_score: '0, out_tag: '0, last: 1'b1};
            end else begin
              state <= S_DUP;
            end
          end
        end
        // search for the same key
        S_DUP: begin
          if (scan < live_count) scan <= scan + 1'b1;
          rd_vld <= (scan < live_count);
          if (dup_hit) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
            if (better(in_cand, ram_rdata)) begin
              out_data <= '{status: ST_REP_DUP, entry_present: 1'b1,
                            out_key_high: ram_rdata.key_high,
                            out_key_low: ram_rdata.key_low,
                            out_score: ram_rdata.score, out_tag: ram_rdata.tag,
                            last: 1'b1};
              ram_we    <= 1'b1;
              ram_waddr <= rd_idx[IdxW-1:0];
              ram_wdata <= in_cand;
            end else begin
              out_data <= '{status: ST_REJECT, entry_present: 1'b0,
                            out_key_high: '0, out_key_low: '0,
                            out_score: '0, out_tag: '0, last: 1'b1};
            end
          end else if (scan >= live_count && !rd_vld) begin
            if (live_count < width_eff) begin
              ram_we     <= 1'b1;
              ram_waddr  <= live_count[IdxW-1:0];
              ram_wdata  <= in_cand;
              live_count <= live_count + 1'b1;
              out_valid  <= 1'b1;
              out_data   <= '{status: ST_INSERT, entry_present: 1'b0,
                              out_key_high: '0, out_key_low: '0,
                              out_score: '0, out_tag: '0, last: 1'b1};
              state      <= S_IDLE;
            end else begin
              scan  <= '0;
              state <= S_WORST;
            end
          end
        end
        // find the worst held entry
        S_WORST: begin
          if (scan < live_count) scan <= scan + 1'b1;
          rd_vld <= (scan < live_count);
          if (rd_vld && (!have_best || better(best, ram_rdata))) begin
            best      <= ram_rdata;
            best_idx  <= rd_idx[IdxW-1:0];
            have_best <= 1'b1;
          end
          if (scan >= live_count && !rd_vld) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
            if (better(in_cand, best)) begin
              out_data <= '{status: ST_REP_WST, entry_present: 1'b1,
                            out_key_high: best.key_high,
                            out_key_low: best.key_low,
                            out_score: best.score, out_tag: best.tag,
                            last: 1'b1};
              ram_we    <= 1'b1;
              ram_waddr <= best_idx;
              ram_wdata <= in_cand;
            end else begin
              out_data <= '{status: ST_REJECT, entry_present: 1'b0,
                            out_key_high: '0, out_key_low: '0,
                            out_score: '0, out_tag: '0, last: 1'b1};
            end
          end
        end
        // drain: find best of the remaining entries
        S_SEL: begin
          if (scan < remain) scan <= scan + 1'b1;
          rd_vld <= (scan < remain);
          if (rd_vld && (!have_best || better(ram_rdata, best))) begin
            best      <= ram_rdata;
            best_idx  <= rd_idx[IdxW-1:0];
            have_best <= 1'b1;
          end
          if (scan >= remain && !rd_vld) state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_data  <= '{status: ST_DRAINED, entry_present: 1'b1,
                           out_key_high: best.key_high, out_key_low: best.key_low,
                           out_score: best.score, out_tag: best.tag,
                           last: (remain == CntW'(1))};
            remain    <= remain - 1'b1;
            mv_src    <= remain - 1'b1;
            state     <= S_OUT;
          end
        end
        // move the top entry into the emitted slot
        S_OUT: begin
          if (remain == '0) begin
            live_count <= '0;
            state      <= S_IDLE;
          end else begin
            state <= S_MOVE;
          end
        end
        S_MOVE: begin
          ram_we    <= 1'b1;
          ram_waddr <= best_idx;
          ram_wdata <= ram_rdata;
          scan      <= '0;
          have_best <= 1'b0;
          state     <= S_WAIT;
        end
        // let the move land before the next scan reads
        S_WAIT: begin
          state <= S_SEL;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `DTK_ASSERT(a_no_accept_busy, clk, rst, (state != S_IDLE) |-> !in_ready,
              "input accepted while busy")
  `DTK_ASSERT(a_count_cap, clk, rst, live_count <= CntW'(MaxEntries),
              "live count above capacity")
  `DTK_ASSERT(a_insert_grows, clk, rst,
              (out_valid && !$past(out_valid) && out_data.status == ST_INSERT)
              |-> live_count == $past(live_count) + 1'b1,
              "insert without count growth")
  `DTK_ASSERT_RST(a_reset_idle, clk, $past(rst) |-> (state == S_IDLE && !out_valid),
                  "not idle after reset")
endmodule
